@@ hw/rtl/cht_pkg.sv @@
// Shared types and constants for the chained hash table engine.
// Used by cht_ctrl, cht_dp and chained_hash_table_engine_top. No dependencies.
`default_nettype none
package cht_pkg;

  localparam int KEY_W = 64;
  localparam int VAL_W = 32;
  localparam int WORD_W = 64;
  localparam int CFG_W = 9;
  localparam int TOTAL_W = 9;
  localparam logic [CFG_W-1:0] RESET_BUCKETS = 9'd109;
  localparam int MOD_BITS_PER_STEP = 8;
  localparam int MOD_STEPS = KEY_W / MOD_BITS_PER_STEP;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_MISSING  = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4,
    ST_KEY_ZERO = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [WORD_W-1:0]       first_payload;
    logic [WORD_W-1:0]       second_payload;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] found_value;
    logic [WORD_W-1:0]       found_first;
    logic [WORD_W-1:0]       found_second;
    logic [TOTAL_W-1:0]      entry_total;
  } res_t;

  typedef struct packed {
    logic    clear_step;
    logic    accept;
    logic    mod_step;
    logic    head_rd;
    logic    head_take;
    logic    walk_rd;
    logic    walk_adv;
    logic    lookup_ld;
    logic    upd_wr;
    logic    free_rd;
    logic    ins_wr;
    logic    ins_link;
    logic    rem_unlink;
    logic    rem_free;
    logic    status_ld;
    status_t status;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    logic       in_key_zero;
    logic [1:0] in_kind;
    logic [1:0] kind;
    logic       mod_done;
    logic       clear_done;
    logic       cur_null;
    logic       prev_null;
    logic       key_match;
    logic       free_null;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/chained_hash_table_engine_top.sv @@
// Top level of the chained hash table engine: cht_ctrl and cht_dp.
// Depends on cht_pkg, cht_ctrl and cht_dp.
//
//   channel  ports                            role
//   in       in_valid, in_stall, in_data      request beat (kind, key, value, payloads)
//   out      out_valid, out_stall, out_data   result beat, one per request
//   cfg      cfg_we, cfg_data                 bucket_count register write
//
// A request runs from its accepting edge through these steps: one idle state to accept, the
// key modulo unit, the bucket head read and take, a read and a compare on the entry memory
// port per chain entry visited, and then the states that end the walk, write the entry and
// load the result register.
// Key zero and unknown kinds skip the modulo unit and the walk and go to the result state.
// After reset a clearing pass over max(POOL_ENTRIES, MAX_BUCKETS) addresses sets up the
// bucket heads and the free list; in_stall is high during it.
// A waiting result beat does not block the next request until its own result is ready.
`default_nettype none
module chained_hash_table_engine_top #(
  parameter int POOL_ENTRIES = 256,
  parameter int MAX_BUCKETS = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire cht_pkg::req_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output cht_pkg::res_t                   out_data,
  input  wire logic                       cfg_we,
  input  wire logic [cht_pkg::CFG_W-1:0]  cfg_data
);

  cht_pkg::cmd_t cmd;
  cht_pkg::sts_t sts;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (in_stall)
  );

  cht_dp #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .MAX_BUCKETS  (MAX_BUCKETS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_link_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_step, cmd.ins_wr, cmd.ins_link, cmd.rem_unlink, cmd.rem_free}))
    else $error("more than one link memory write in a cycle");

  a_insert_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.free_rd |-> !sts.free_null)
    else $error("insert started with an empty free list");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("result loaded over a waiting beat");

  a_result_taken_once: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !cmd.out_ld) |=> !out_valid)
    else $error("result beat repeated");

endmodule
`default_nettype wire

@@ hw/rtl/cht_ctrl.sv @@
// Controller state machine of the chained hash table engine.
// Depends on cht_pkg; drives the commands of cht_dp from its status.
`default_nettype none
module cht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire cht_pkg::sts_t sts,
  output cht_pkg::cmd_t      cmd,
  output logic               busy
);

  typedef enum logic [10:0] {
    S_CLEAR     = 11'b000_0000_0001,
    S_IDLE      = 11'b000_0000_0010,
    S_MOD       = 11'b000_0000_0100,
    S_HEAD_RD   = 11'b000_0000_1000,
    S_HEAD_TAKE = 11'b000_0001_0000,
    S_WALK_RD   = 11'b000_0010_0000,
    S_WALK_CMP  = 11'b000_0100_0000,
    S_REM2      = 11'b000_1000_0000,
    S_INS       = 11'b001_0000_0000,
    S_INS2      = 11'b010_0000_0000,
    S_RESULT    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.status = cht_pkg::ST_MISSING;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_key_zero) begin
            cmd.status_ld = 1'b1;
            cmd.status = cht_pkg::ST_KEY_ZERO;
            state_nxt = S_RESULT;
          end else if (sts.in_kind == cht_pkg::KIND_INSERT ||
                       sts.in_kind == cht_pkg::KIND_LOOKUP ||
                       sts.in_kind == cht_pkg::KIND_REMOVE) begin
            state_nxt = S_MOD;
          end else begin
            cmd.status_ld = 1'b1;
            cmd.status = cht_pkg::ST_MISSING;
            state_nxt = S_RESULT;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_nxt = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
        state_nxt = S_HEAD_TAKE;
      end
      S_HEAD_TAKE: begin
        cmd.head_take = 1'b1;
        state_nxt = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (sts.cur_null) begin
          if (sts.kind == cht_pkg::KIND_INSERT) begin
            if (sts.free_null) begin
              cmd.status_ld = 1'b1;
              cmd.status = cht_pkg::ST_FULL;
              state_nxt = S_RESULT;
            end else begin
              cmd.free_rd = 1'b1;
              state_nxt = S_INS;
            end
          end else begin
            cmd.status_ld = 1'b1;
            cmd.status = cht_pkg::ST_MISSING;
            state_nxt = S_RESULT;
          end
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt = S_WALK_CMP;
        end
      end
      S_WALK_CMP: begin
        if (sts.key_match) begin
          case (sts.kind)
            cht_pkg::KIND_LOOKUP: begin
              cmd.lookup_ld = 1'b1;
              cmd.status_ld = 1'b1;
              cmd.status = cht_pkg::ST_FOUND;
              state_nxt = S_RESULT;
            end
            cht_pkg::KIND_INSERT: begin
              cmd.upd_wr = 1'b1;
              cmd.status_ld = 1'b1;
              cmd.status = cht_pkg::ST_UPDATED;
              state_nxt = S_RESULT;
            end
            default: begin
              cmd.rem_unlink = 1'b1;
              state_nxt = S_REM2;
            end
          endcase
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt = S_WALK_RD;
        end
      end
      S_REM2: begin
        cmd.rem_free = 1'b1;
        cmd.status_ld = 1'b1;
        cmd.status = cht_pkg::ST_FOUND;
        state_nxt = S_RESULT;
      end
      S_INS: begin
        cmd.ins_wr = 1'b1;
        if (sts.prev_null) begin
          cmd.status_ld = 1'b1;
          cmd.status = cht_pkg::ST_INSERTED;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_INS2;
        end
      end
      S_INS2: begin
        cmd.ins_link = 1'b1;
        cmd.status_ld = 1'b1;
        cmd.status = cht_pkg::ST_INSERTED;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cht_dp.sv @@
// Datapath of the chained hash table engine: key modulo unit, bucket and entry memories,
// chain pointers, free list, entry count and the result register.
// Depends on cht_pkg; commanded by cht_ctrl.
`default_nettype none
module cht_dp #(
  parameter int POOL_ENTRIES = 256,
  parameter int MAX_BUCKETS = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire cht_pkg::req_t               in_data,
  input  wire logic                        cfg_we,
  input  wire logic [cht_pkg::CFG_W-1:0]   cfg_data,
  input  wire cht_pkg::cmd_t               cmd,
  output cht_pkg::sts_t                    sts,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output cht_pkg::res_t                    out_data
);

  localparam int AW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES) + 1;
  localparam int BW = $clog2(MAX_BUCKETS);
  localparam int NW = $clog2(MAX_BUCKETS + 1);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int CLR_N = (POOL_ENTRIES > MAX_BUCKETS) ? POOL_ENTRIES : MAX_BUCKETS;
  localparam int KW = $clog2(CLR_N);
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_ENTRIES);

  logic [LW-1:0]                  heads_mem [MAX_BUCKETS];
  logic [cht_pkg::KEY_W-1:0]      keys_mem [POOL_ENTRIES];
  logic [cht_pkg::VAL_W-1:0]      vals_mem [POOL_ENTRIES];
  logic [cht_pkg::WORD_W-1:0]     firsts_mem [POOL_ENTRIES];
  logic [cht_pkg::WORD_W-1:0]     seconds_mem [POOL_ENTRIES];
  logic [LW-1:0]                  links_mem [POOL_ENTRIES];

  cht_pkg::req_t                  req_r;
  logic [cht_pkg::CFG_W-1:0]      cfg_r;
  logic [NW-1:0]                  rem_r, rem_nxt;
  logic [cht_pkg::KEY_W-1:0]      key_sh_r;
  logic [2:0]                     mod_cnt_r;
  logic [KW-1:0]                  clr_r;
  logic [LW-1:0]                  cur_r, prev_r, free_head_r, fresh_r, head_q_r;
  logic [CW-1:0]                  count_r;
  cht_pkg::status_t               status_r;
  logic [cht_pkg::VAL_W-1:0]      fv_r;
  logic [cht_pkg::WORD_W-1:0]     ff_r, fs_r;
  logic [cht_pkg::KEY_W-1:0]      key_q_r;
  logic [cht_pkg::VAL_W-1:0]      val_q_r;
  logic [cht_pkg::WORD_W-1:0]     first_q_r, second_q_r;
  logic [LW-1:0]                  link_q_r;
  logic                           out_valid_r;
  cht_pkg::res_t                  out_data_r;

  logic [31:0]                    cfg_ext, n32, clr_ext, cnt_ext;
  logic [NW-1:0]                  n_eff;
  logic [BW-1:0]                  bucket;
  logic                           clr_in_heads, clr_in_pool;
  logic                           head_we;
  logic [BW-1:0]                  head_wa;
  logic [LW-1:0]                  head_wd;
  logic                           link_we;
  logic [AW-1:0]                  link_wa;
  logic [LW-1:0]                  link_wd;
  logic                           ent_we, ent_re;
  logic [AW-1:0]                  ent_wa, ent_ra;

  assign cfg_ext = 32'(cfg_r);
  assign n32 = (cfg_ext == 32'd0) ? 32'd1 :
               ((cfg_ext > 32'(MAX_BUCKETS)) ? 32'(MAX_BUCKETS) : cfg_ext);
  assign n_eff = n32[NW-1:0];
  assign bucket = rem_r[BW-1:0];

  // Eight restoring remainder steps per cycle, key bits taken from the top.
  always_comb begin
    logic [NW:0]   t;
    logic [NW-1:0] r;
    r = rem_r;
    for (int j = 0; j < cht_pkg::MOD_BITS_PER_STEP; j++) begin
      t = {r, key_sh_r[cht_pkg::KEY_W-1-j]};
      if (t >= {1'b0, n_eff}) begin
        r = NW'(t - {1'b0, n_eff});
      end else begin
        r = t[NW-1:0];
      end
    end
    rem_nxt = r;
  end

  assign clr_ext = 32'(clr_r);
  assign clr_in_heads = (clr_ext < 32'(MAX_BUCKETS));
  assign clr_in_pool = (clr_ext < 32'(POOL_ENTRIES));

  assign head_we = (cmd.clear_step && clr_in_heads) ||
                   ((cmd.ins_wr || cmd.rem_unlink) && sts.prev_null);
  assign head_wa = cmd.clear_step ? clr_r[BW-1:0] : bucket;
  assign head_wd = cmd.clear_step ? NULL_LINK : (cmd.ins_wr ? free_head_r : link_q_r);

  always_comb begin
    link_we = 1'b0;
    link_wa = cur_r[AW-1:0];
    link_wd = free_head_r;
    if (cmd.clear_step) begin
      link_we = clr_in_pool;
      link_wa = clr_r[AW-1:0];
      link_wd = LW'(clr_ext + 32'd1);
    end else if (cmd.ins_wr) begin
      link_we = 1'b1;
      link_wa = free_head_r[AW-1:0];
      link_wd = NULL_LINK;
    end else if (cmd.ins_link) begin
      link_we = 1'b1;
      link_wa = prev_r[AW-1:0];
      link_wd = fresh_r;
    end else if (cmd.rem_unlink) begin
      link_we = !sts.prev_null;
      link_wa = prev_r[AW-1:0];
      link_wd = link_q_r;
    end else if (cmd.rem_free) begin
      link_we = 1'b1;
      link_wa = cur_r[AW-1:0];
      link_wd = free_head_r;
    end
  end

  assign ent_we = cmd.ins_wr || cmd.upd_wr;
  assign ent_wa = cmd.ins_wr ? free_head_r[AW-1:0] : cur_r[AW-1:0];
  assign ent_re = cmd.walk_rd || cmd.free_rd;
  assign ent_ra = cmd.walk_rd ? cur_r[AW-1:0] : free_head_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (head_we) heads_mem[head_wa] <= head_wd;
    if (cmd.head_rd) head_q_r <= heads_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (link_we) links_mem[link_wa] <= link_wd;
    if (ent_re) link_q_r <= links_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_wr) keys_mem[ent_wa] <= req_r.key;
    if (ent_we) begin
      vals_mem[ent_wa] <= req_r.value;
      firsts_mem[ent_wa] <= req_r.first_payload;
      seconds_mem[ent_wa] <= req_r.second_payload;
    end
    if (ent_re) begin
      key_q_r <= keys_mem[ent_ra];
      val_q_r <= vals_mem[ent_ra];
      first_q_r <= firsts_mem[ent_ra];
      second_q_r <= seconds_mem[ent_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data;
      key_sh_r <= in_data.key;
      rem_r <= '0;
      fv_r <= '0;
      ff_r <= '0;
      fs_r <= '0;
    end
    if (cmd.mod_step) begin
      rem_r <= rem_nxt;
      key_sh_r <= key_sh_r << cht_pkg::MOD_BITS_PER_STEP;
    end
    if (cmd.head_take) begin
      cur_r <= head_q_r;
      prev_r <= NULL_LINK;
    end
    if (cmd.walk_adv) begin
      prev_r <= cur_r;
      cur_r <= link_q_r;
    end
    if (cmd.ins_wr) fresh_r <= free_head_r;
    if (cmd.status_ld) status_r <= cmd.status;
    if (cmd.lookup_ld) begin
      fv_r <= val_q_r;
      ff_r <= first_q_r;
      fs_r <= second_q_r;
    end
    if (cmd.out_ld) begin
      out_data_r.status <= status_r;
      out_data_r.found_value <= fv_r;
      out_data_r.found_first <= ff_r;
      out_data_r.found_second <= fs_r;
      out_data_r.entry_total <= cnt_ext[cht_pkg::TOTAL_W-1:0];
    end
  end

  assign cnt_ext = 32'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cht_pkg::RESET_BUCKETS;
      mod_cnt_r <= '0;
      clr_r <= '0;
      free_head_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cfg_r <= cfg_data;
      if (cmd.accept) begin
        mod_cnt_r <= '0;
      end else if (cmd.mod_step) begin
        mod_cnt_r <= mod_cnt_r + 3'd1;
      end
      if (cmd.clear_step && !sts.clear_done) clr_r <= clr_r + KW'(1);
      if (cmd.ins_wr) begin
        free_head_r <= link_q_r;
        count_r <= count_r + CW'(1);
      end else if (cmd.rem_free) begin
        free_head_r <= cur_r;
        if (count_r != '0) count_r <= count_r - CW'(1);
      end
      out_valid_r <= cmd.out_ld || (out_valid_r && out_stall);
    end
  end

  always_comb begin
    sts.in_key_zero = (in_data.key == '0);
    sts.in_kind = in_data.kind;
    sts.kind = req_r.kind;
    sts.mod_done = (mod_cnt_r == 3'(cht_pkg::MOD_STEPS - 1));
    sts.clear_done = (clr_r == KW'(CLR_N - 1));
    sts.cur_null = (cur_r >= NULL_LINK);
    sts.prev_null = (prev_r >= NULL_LINK);
    sts.key_match = (key_q_r == req_r.key);
    sts.free_null = (free_head_r >= NULL_LINK);
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
`default_nettype wire
